### rtl/core/ordered_list_insert_delete_search_top_defines.svh
// assertion macros for the ordered list block
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OLIDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olids check failed");
// next-cycle implication
`define OLIDS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olids check failed");
`else
`define OLIDS_ASSERT_IMP(label, clk, rst, ante, cons)
`define OLIDS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/olids_pkg.sv
package olids_pkg;

   localparam int DEPTH_DEF = 128;

   localparam int CMD_W     = 2;
   localparam int POS_W     = 7;
   localparam int VAL_W     = 32;
   localparam int IDX_W     = 7;
   localparam int CNT_OUT_W = 8;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   typedef struct packed {
      logic                 accepted;
      logic                 found;
      logic [IDX_W-1:0]     found_index;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

endpackage

### rtl/core/olids_ram.sv
module olids_ram #(
   parameter int DEPTH = olids_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [olids_pkg::VAL_W-1:0]         wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [olids_pkg::VAL_W-1:0]         rd_data
);
   import olids_pkg::*;

   logic [VAL_W-1:0] mem_ff [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/olids_seq.sv
module olids_seq #(
   parameter int DEPTH = olids_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [olids_pkg::CMD_W-1:0]         req_cmd,
   input  logic [olids_pkg::POS_W-1:0]         req_position,
   input  logic signed [olids_pkg::VAL_W-1:0]  req_item_value,
   input  logic                                rsp_free,
   output logic                                rsp_push,
   output olids_pkg::rsp_type                  rsp_data,
   output logic                                mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]            mem_wr_addr,
   output logic [olids_pkg::VAL_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]            mem_rd_addr,
   input  logic [olids_pkg::VAL_W-1:0]         mem_rd_data
);
   import olids_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int EXT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MOVE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] rd_ff, rd_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic              more_ff, more_in;
   logic              pw_vld_ff, pw_vld_in;
   logic [ADDR_W-1:0] pw_addr_ff, pw_addr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              ok_ff, ok_in;
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] where_ff, where_in;

   logic [EXT_W-1:0]  pos_ext, cnt_ext;
   logic              ins_ok, del_ok, ins_mv, del_mv, srch_go;
   logic              is_ins, fin_wr;
   logic [CNT_W-1:0]  count_upd;

   // request checks against the current count
   always_comb begin
      pos_ext = EXT_W'(req_position);
      cnt_ext = EXT_W'(count_ff);
      ins_ok  = (req_cmd == CMD_INSERT) && (pos_ext <= cnt_ext) &&
                (count_ff < CNT_W'(DEPTH));
      del_ok  = (req_cmd == CMD_DELETE) && (pos_ext < cnt_ext);
      ins_mv  = ins_ok && (pos_ext < cnt_ext);
      del_mv  = del_ok && (pos_ext < (cnt_ext - EXT_W'(1)));
      srch_go = (req_cmd == CMD_SEARCH) && (count_ff != '0);
   end

   assign is_ins = (cmd_ff == CMD_INSERT);

   always_comb begin
      if (ok_ff && is_ins) begin
         count_upd = count_ff + CNT_W'(1);
      end else if (ok_ff && (cmd_ff == CMD_DELETE)) begin
         count_upd = count_ff - CNT_W'(1);
      end else begin
         count_upd = count_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      count_in   = count_ff;
      rd_in      = rd_ff;
      end_in     = end_ff;
      more_in    = more_ff;
      pw_vld_in  = 1'b0;
      pw_addr_in = pw_addr_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      ok_in      = ok_ff;
      hit_in     = hit_ff;
      where_in   = where_ff;
      mem_rd_en  = 1'b0;
      mem_rd_addr = rd_ff;
      fin_wr     = 1'b0;
      rsp_push   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               pos_in   = ADDR_W'(req_position);
               val_in   = req_item_value;
               ok_in    = ins_ok || del_ok;
               hit_in   = 1'b0;
               where_in = '0;
               more_in  = 1'b1;
               if (ins_mv) begin
                  // walk down from the top entry to the insert point
                  rd_in    = ADDR_W'(count_ff - CNT_W'(1));
                  end_in   = ADDR_W'(req_position);
                  state_in = ST_MOVE;
               end else if (del_mv) begin
                  // walk up from just above the hole to the top entry
                  rd_in    = ADDR_W'(pos_ext + EXT_W'(1));
                  end_in   = ADDR_W'(count_ff - CNT_W'(1));
                  state_in = ST_MOVE;
               end else if (srch_go) begin
                  rd_in    = '0;
                  end_in   = ADDR_W'(count_ff - CNT_W'(1));
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MOVE: begin
            if (more_ff) begin
               mem_rd_en  = 1'b1;
               pw_vld_in  = 1'b1;
               pw_addr_in = is_ins ? (rd_ff + ADDR_W'(1)) : (rd_ff - ADDR_W'(1));
               if (rd_ff == end_ff) begin
                  more_in = 1'b0;
               end else begin
                  rd_in = is_ins ? (rd_ff - ADDR_W'(1)) : (rd_ff + ADDR_W'(1));
               end
            end else begin
               // last moved word is written this cycle
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && (mem_rd_data == val_ff)) begin
               hit_in   = 1'b1;
               where_in = cmp_idx_ff;
               more_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (more_ff) begin
               mem_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_ff;
               if (rd_ff == end_ff) begin
                  more_in = 1'b0;
               end else begin
                  rd_in = rd_ff + ADDR_W'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_push = 1'b1;
               fin_wr   = ok_ff && is_ins;
               count_in = count_upd;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // moved words and the inserted value share the write port, never in the same cycle
   always_comb begin
      mem_wr_en = pw_vld_ff || fin_wr;
      if (pw_vld_ff) begin
         mem_wr_addr = pw_addr_ff;
         mem_wr_data = mem_rd_data;
      end else begin
         mem_wr_addr = pos_ff;
         mem_wr_data = val_ff;
      end
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_data.accepted    = ok_ff;
   assign rsp_data.found       = hit_ff;
   assign rsp_data.found_index = IDX_W'(where_ff);
   assign rsp_data.entry_count = CNT_OUT_W'(count_upd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         more_ff    <= 1'b0;
         pw_vld_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         more_ff    <= more_in;
         pw_vld_ff  <= pw_vld_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      rd_ff      <= rd_in;
      end_ff     <= end_in;
      pw_addr_ff <= pw_addr_in;
      cmp_idx_ff <= cmp_idx_in;
      ok_ff      <= ok_in;
      hit_ff     <= hit_in;
      where_ff   <= where_in;
   end

endmodule

### rtl/core/ordered_list_insert_delete_search_top.sv
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_ready  | req_cmd, req_position, req_item_value
// rsp      | out       | rsp_valid/rsp_ready  | rsp_accepted, rsp_found, rsp_found_index,
//          |           |                      | rsp_entry_count
//
// one request in flight; the list walk is one memory word per cycle
// reset clears the count and the control state; the entry memory is not cleared
// a finished result sits in the output register, so the next request is taken while it waits
// a stalled rsp side holds the sequencer in its finish step until the register frees

`include "ordered_list_insert_delete_search_top_defines.svh"

module ordered_list_insert_delete_search_top #(
   parameter int DEPTH = olids_pkg::DEPTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [olids_pkg::CMD_W-1:0]             req_cmd,
   input  logic [olids_pkg::POS_W-1:0]             req_position,
   input  logic signed [olids_pkg::VAL_W-1:0]      req_item_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_accepted,
   output logic                                    rsp_found,
   output logic [olids_pkg::IDX_W-1:0]             rsp_found_index,
   output logic [olids_pkg::CNT_OUT_W-1:0]         rsp_entry_count
);
   import olids_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   // sequencer to memory
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [VAL_W-1:0]  mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [VAL_W-1:0]  mem_rd_data;

   // sequencer to output register
   logic    rsp_free;
   logic    rsp_push;
   rsp_type seq_rsp;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   olids_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   olids_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_free       (rsp_free),
      .rsp_push       (rsp_push),
      .rsp_data       (seq_rsp),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // register is free when empty or when its transfer completes this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_data_ff.accepted;
   assign rsp_found       = rsp_data_ff.found;
   assign rsp_found_index = rsp_data_ff.found_index;
   assign rsp_entry_count = rsp_data_ff.entry_count;

   // a result never overwrites one that is still waiting
   `OLIDS_ASSERT_IMP(a_push_free, clock, reset, rsp_push, rsp_free)
   // only one request in flight
   `OLIDS_ASSERT_NXT(a_one_busy, clock, reset, req_valid && req_ready, !req_ready)
   // a search hit never reports a carried-out insert or delete
   `OLIDS_ASSERT_IMP(a_hit_excl, clock, reset, rsp_valid && rsp_found, !rsp_accepted)
   // a miss reports index zero
   `OLIDS_ASSERT_IMP(a_miss_idx, clock, reset, rsp_valid && !rsp_found, rsp_found_index == '0)

endmodule

### sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import olids_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;
   // cmd code with no operation behind it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // cycles with no transfer on either channel before the run is abandoned
   localparam int STALL_LIMIT = 4000;
   // quiet cycles after the last result, well past the longest list walk
   localparam int TAIL_CYCLES = 300;

   typedef enum int {
      TREND_GROW,
      TREND_SHRINK,
      TREND_HOVER
   } trend_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_cmd = CMD_INSERT;
   logic [POS_W-1:0]       req_position = '0;
   logic signed [VAL_W-1:0] req_item_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_accepted;
   logic                   rsp_found;
   logic [IDX_W-1:0]       rsp_found_index;
   logic [CNT_OUT_W-1:0]   rsp_entry_count;

   // shadow copy of the list contents and length
   logic signed [VAL_W-1:0] shadow_entries [LIST_DEPTH];
   int unsigned             shadow_count = 0;

   // outcomes still owed by the block, oldest first
   rsp_type                 outcome_q [$];
   rsp_type                 oldest_outcome;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatches         = 0;
   int results_seen       = 0;
   int requests_sent      = 0;
   int inserts_done       = 0;
   int deletes_done       = 0;
   int search_hits        = 0;
   int rejects_seen       = 0;
   int peak_count         = 0;
   int quiet_cycles       = 0;

   ordered_list_insert_delete_search_top #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_found      (rsp_found),
      .rsp_found_index(rsp_found_index),
      .rsp_entry_count(rsp_entry_count)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow list and return the outcome it must produce
   function automatic rsp_type apply_list_op(input logic [CMD_W-1:0] cmd,
                                             input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] val);
      rsp_type     outcome;
      int unsigned i;
      outcome = '0;
      case (cmd)
         CMD_INSERT: begin
            if (pos <= shadow_count && shadow_count < LIST_DEPTH) begin
               // open a hole at pos by moving the tail up one place
               for (i = shadow_count; i > pos; i--)
                  shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[pos] = val;
               shadow_count++;
               outcome.accepted = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (pos < shadow_count) begin
               // close the gap by moving the tail down one place
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i + 1];
               shadow_count--;
               outcome.accepted = 1'b1;
            end
         end
         CMD_SEARCH: begin
            // first match wins, so duplicates report the lowest index
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_entries[i] == val) begin
                  outcome.found       = 1'b1;
                  outcome.found_index = i[IDX_W-1:0];
                  break;
               end
            end
         end
         default: begin
            // unused command leaves everything alone
         end
      endcase
      outcome.entry_count = shadow_count[CNT_OUT_W-1:0];
      return outcome;
   endfunction

   // now and then a value from a small pool so duplicates and extremes show up often
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] val;
      val = $urandom;
      if ($urandom_range(0, 99) < 35) begin
         case ($urandom_range(0, 6))
            0: val = 32'sh8000_0000;
            1: val = 32'sh7fff_ffff;
            2: val = 32'sh0000_0000;
            3: val = -32'sd1;
            4: val = 32'sd1;
            5: val = 32'sd5;
            default: val = -32'sd5;
         endcase
      end
      return val;
   endfunction

   // search for a stored value most of the time, else anything
   function automatic logic signed [VAL_W-1:0] pick_search_value();
      if (shadow_count > 0 && $urandom_range(0, 99) < 60)
         return shadow_entries[$urandom_range(0, shadow_count - 1)];
      return pick_value();
   endfunction

   // one transfer on the request channel, then book the outcome it owes
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
      int      gap;
      rsp_type outcome;
      gap = 0;
      while (gap < 200 && $urandom_range(0, 99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_position   <= pos;
      req_item_value <= val;
      do @(posedge clock); while (!req_ready);
      // valid stays high here; the next call or the drain lowers it
      outcome = apply_list_op(cmd, pos, val);
      outcome_q.push_back(outcome);
      requests_sent++;
      if (outcome.accepted && cmd == CMD_INSERT)
         inserts_done++;
      if (outcome.accepted && cmd == CMD_DELETE)
         deletes_done++;
      if (outcome.found)
         search_hits++;
      if ((cmd == CMD_INSERT || cmd == CMD_DELETE) && !outcome.accepted)
         rejects_seen++;
      if (shadow_count > peak_count)
         peak_count = shadow_count;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // corner cases on an empty and a short list
   task automatic test_short_list_corners();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // empty list: miss, rejected delete, insert past the end
      send_request(CMD_SEARCH, 7'd0, 32'sd0);
      send_request(CMD_DELETE, 7'd0, 32'sd0);
      send_request(CMD_INSERT, 7'd1, 32'sd9);
      // build min, max at the tail, then front and middle inserts
      send_request(CMD_INSERT, 7'd0, 32'sh8000_0000);
      send_request(CMD_INSERT, 7'd1, 32'sh7fff_ffff);
      send_request(CMD_INSERT, 7'd0, 32'sd0);
      send_request(CMD_INSERT, 7'd1, -32'sd1);
      // duplicate of max in front: search must report the lowest index
      send_request(CMD_INSERT, 7'd0, 32'sh7fff_ffff);
      send_request(CMD_SEARCH, 7'd127, 32'sh7fff_ffff);
      send_request(CMD_SEARCH, 7'd0, 32'sh8000_0000);
      send_request(CMD_SEARCH, 7'd0, 32'sd12345);
      // unused command with every field bit high, then with every one low
      send_request(CMD_UNUSED, 7'd127, -32'sd1);
      send_request(CMD_UNUSED, 7'd0, 32'sd0);
      // deletes out of range, at the tail, in the middle and at the front
      send_request(CMD_DELETE, 7'd127, 32'sd0);
      send_request(CMD_DELETE, 7'd5, 32'sd0);
      send_request(CMD_DELETE, 7'd4, -32'sd1);
      send_request(CMD_DELETE, 7'd1, 32'sd0);
      send_request(CMD_DELETE, 7'd0, 32'sd0);
      send_request(CMD_INSERT, 7'd127, 32'sd3);
      send_request(CMD_SEARCH, 7'd0, 32'sh7fff_ffff);
      send_request(CMD_SEARCH, 7'd0, -32'sd1);
      // insert at position equal to the count appends
      send_request(CMD_INSERT, 7'd2, 32'sh5a5a_a5a5);
      send_request(CMD_SEARCH, 7'd0, 32'sh5a5a_a5a5);
   endtask

   // fill to capacity, poke the full list, then drain it
   task automatic test_full_list();
      int k;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      while (shadow_count < LIST_DEPTH)
         send_request(CMD_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_value());
      // full: inserts at both ends are rejected
      send_request(CMD_INSERT, 7'd0, 32'sd1);
      send_request(CMD_INSERT, 7'd127, 32'sd1);
      send_request(CMD_SEARCH, 7'd0, shadow_entries[LIST_DEPTH - 1]);
      send_request(CMD_SEARCH, 7'd0, $urandom);
      send_request(CMD_DELETE, 7'd127, 32'sd0);
      send_request(CMD_INSERT, 7'd127, 32'sh1234_5678);
      send_request(CMD_SEARCH, 7'd0, 32'sh1234_5678);
      k = 0;
      while (shadow_count > 0) begin
         if (k % 4 == 3)
            send_request(CMD_SEARCH, POS_W'($urandom), pick_search_value());
         else
            send_request(CMD_DELETE, POS_W'($urandom_range(0, shadow_count - 1)), $urandom);
         k++;
      end
   endtask

   // random traffic that drifts the list length up and down
   task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
      trend_type           trend;
      int                  roll;
      int                  ins_lim;
      int                  del_lim;
      int                  k;
      logic [CMD_W-1:0]    cmd;
      logic [POS_W-1:0]    pos;
      logic signed [VAL_W-1:0] val;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      trend              = TREND_HOVER;
      for (k = 0; k < n_items; k++) begin
         if (k % 90 == 0)
            trend = trend_type'($urandom_range(0, 2));
         case (trend)
            TREND_GROW:   begin ins_lim = 60; del_lim = 78; end
            TREND_SHRINK: begin ins_lim = 20; del_lim = 70; end
            default:      begin ins_lim = 36; del_lim = 70; end
         endcase
         roll = $urandom_range(0, 99);
         pos  = POS_W'($urandom);
         val  = pick_value();
         if (roll < ins_lim) begin
            cmd = CMD_INSERT;
            // mostly legal positions, now and then anything
            if (shadow_count < LIST_DEPTH && $urandom_range(0, 9) != 0)
               pos = POS_W'($urandom_range(0, shadow_count));
         end else if (roll < del_lim) begin
            cmd = CMD_DELETE;
            val = $urandom;
            if (shadow_count > 0 && $urandom_range(0, 9) != 0)
               pos = POS_W'($urandom_range(0, shadow_count - 1));
         end else if (roll < 95) begin
            cmd = CMD_SEARCH;
            val = pick_search_value();
         end else begin
            cmd = CMD_UNUSED;
            val = $urandom;
         end
         send_request(cmd, pos, val);
      end
   endtask

   // receiver stalls at the current rate
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   // every result transfer is matched against the oldest booked outcome
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t ns: unexpected result: accepted %0b found %0b index %0d count %0d",
                     $time, rsp_accepted, rsp_found, rsp_found_index, rsp_entry_count);
            mismatches++;
         end else begin
            oldest_outcome = outcome_q.pop_front();
            check_field("accepted", oldest_outcome.accepted, rsp_accepted);
            check_field("found", oldest_outcome.found, rsp_found);
            check_field("found_index", oldest_outcome.found_index, rsp_found_index);
            check_field("entry_count", oldest_outcome.entry_count, rsp_entry_count);
            results_seen++;
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles, %0d outcomes outstanding",
                  $time, STALL_LIMIT, outcome_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // synchronous reset held at the start, then released
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_short_list_corners();
      test_full_list();
      // idling phases: none, sender idle, receiver stalling, both lightly
      test_random_mix(280, 0, 0);
      test_random_mix(280, 86, 0);
      test_random_mix(280, 0, 86);
      test_random_mix(280, 13, 13);

      // drain: stop sending, wait for every owed result, then stay quiet a while
      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d results: %0d inserts, %0d deletes, %0d rejected",
               requests_sent, results_seen, inserts_done, deletes_done, rejects_seen);
      $display("search hits %0d, list length peaked at %0d of %0d, %0d mismatches",
               search_hits, peak_count, LIST_DEPTH, mismatches);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
